// ===== rtl/core/shifting_fifo_with_search_macros.svh =====
// assertion macros for the shifting fifo with search
`ifndef SHIFTING_FIFO_WITH_SEARCH_MACROS_SVH
`define SHIFTING_FIFO_WITH_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF

`define SFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define SFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/sfs_pkg.sv =====
// types and constants shared by the shifting fifo with search
package sfs_pkg;

    localparam int DEPTH = 16;
    localparam int DataW = 32;
    localparam int FuncW = 3;
    localparam int CapW  = 5;
    localparam int CntW  = $clog2(DEPTH + 1);
    localparam int PosW  = $clog2(DEPTH);
    localparam int CmpW  = (CntW > CapW) ? CntW : CapW;

    localparam logic [FuncW-1:0] FN_ENQ    = 3'd0;
    localparam logic [FuncW-1:0] FN_DEQ    = 3'd1;
    localparam logic [FuncW-1:0] FN_PEEK   = 3'd2;
    localparam logic [FuncW-1:0] FN_SEARCH = 3'd3;
    localparam logic [FuncW-1:0] FN_CLEAR  = 3'd4;

    localparam logic [CapW-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== rtl/core/sfs_cell.sv =====
// one storage cell of the shifting queue with key compare
module sfs_cell
    import sfs_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [DataW-1:0] i_wdata,
    input  logic [DataW-1:0] i_next,
    input  logic [DataW-1:0] i_key,
    output logic [DataW-1:0] o_data,
    output logic             o_match
);

    logic [DataW-1:0] r_data;
    logic [DataW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_wdata;
        end else if (i_ctl.shift) begin
            n_data = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

// ===== rtl/core/shifting_fifo_with_search.sv =====
// top level of the shifting fifo with search
// Queue of signed 32-bit words held in a row of DEPTH cells with the head in
// cell 0. Each request (enqueue, dequeue, peek, search, clear) is handled at
// once: all cells shift or compare against the key in parallel, and the
// result is registered, so it appears in the cycle after the request is taken.
// A new request is taken every cycle while the result register is empty or
// being read, giving one request per cycle; the output register is the only
// thing that can stall the input. Capacity is written through i_cfg_we and
// i_cfg_data; values above DEPTH act as DEPTH and zero makes every enqueue
// report full.
module shifting_fifo_with_search
    import sfs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CapW-1:0]         i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [FuncW-1:0]        i_func,
    input  logic signed [DataW-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic signed [DataW-1:0] o_data,
    output logic [PosW-1:0]         o_position,
    output logic [CntW-1:0]         o_count
);

    logic [CapW-1:0]  r_cap;
    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  n_count;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    logic [DataW-1:0] r_data;
    logic [DataW-1:0] n_data;
    logic [PosW-1:0]  r_pos;
    logic [PosW-1:0]  n_pos;

    logic             in_acc;
    logic             full;
    logic             enq_ok;
    logic             deq_ok;
    logic             found;
    logic [PosW-1:0]  hit_pos;
    logic [DEPTH-1:0] match;
    logic [DataW-1:0] cell_data [DEPTH];
    t_cell_ctl        cell_ctl [DEPTH];

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign full   = (r_count >= CntW'(DEPTH)) || (CmpW'(r_count) >= CmpW'(r_cap));
    assign enq_ok = in_acc && (i_func == FN_ENQ) && !full;
    assign deq_ok = in_acc && (i_func == FN_DEQ) && (r_count != '0);

    // row of cells, each taking its right neighbor on a dequeue
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DataW-1:0] next_data;
        if (g < DEPTH - 1) begin : g_mid
            assign next_data = cell_data[g+1];
        end else begin : g_last
            assign next_data = cell_data[g];
        end

        assign cell_ctl[g].shift = deq_ok;
        assign cell_ctl[g].load  = enq_ok && (r_count == CntW'(g));

        sfs_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_wdata (i_value),
            .i_next  (next_data),
            .i_key   (i_value),
            .o_data  (cell_data[g]),
            .o_match (match[g])
        );
    end

    // lowest matching cell among the held entries
    always_comb begin
        found   = 1'b0;
        hit_pos = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (match[k] && (CntW'(k) < r_count)) begin
                found   = 1'b1;
                hit_pos = PosW'(k);
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_data   = '0;
        n_pos    = '0;
        unique case (i_func)
            FN_ENQ: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CntW'(1);
                end
            end
            FN_DEQ: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_data  = cell_data[0];
                    n_count = r_count - CntW'(1);
                end
            end
            FN_PEEK: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_data = cell_data[0];
                end
            end
            FN_SEARCH: begin
                if (found) begin
                    n_pos = hit_pos;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            FN_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_pos    <= n_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_position  = r_pos;
    assign o_count     = r_count;

    `include "shifting_fifo_with_search_macros.svh"

    `SFS_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CntW'(DEPTH))
    `SFS_ASSERT_NEXT(a_enq_grow, i_clk, i_rst_n, enq_ok, r_count == $past(r_count) + CntW'(1))
    `SFS_ASSERT_NEXT(a_deq_ok, i_clk, i_rst_n, deq_ok, r_out_valid && (r_status == ST_OK))
    `SFS_ASSERT_IMPL(a_hit_held, i_clk, i_rst_n, found, CntW'(hit_pos) < r_count)

endmodule
